@@ hdl/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// bir_pkg: shared types and constants of the bilinear image resizer
// Sizes of the source store, fixed-point widths, register map and the
// request structs passed between the top level and the pixel store.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  localparam int POS_W      = 8;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int SCALE_W    = 24;
  localparam int SCALE_FRAC = 16;
  localparam int FULL_FRAC  = SCALE_FRAC + 1;

  // (2d+1) * scale
  localparam int PROD_W = POS_W + 1 + SCALE_W;
  // source coordinate with COORD_FRAC_BITS fraction bits
  localparam int SX_W   = PROD_W - (FULL_FRAC - COORD_FRAC_BITS);
  localparam int IX_W   = PROD_W - FULL_FRAC;
  localparam int WT_W   = COORD_FRAC_BITS + 1;
  localparam int HSUM_W = PIX_W + COORD_FRAC_BITS;
  localparam int VSUM_W = HSUM_W + COORD_FRAC_BITS;

  localparam logic [PROD_W-1:0] HALF_FULL = PROD_W'(1) << SCALE_FRAC;
  localparam logic [WT_W-1:0]   WT_ONE    = WT_W'(1) << COORD_FRAC_BITS;
  localparam logic [VSUM_W:0]   ROUND_ADD = (VSUM_W + 1)'(1) << (2 * COORD_FRAC_BITS - 1);

  localparam int BANK_AW    = (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_X_SCALE    = 3'd3,
    REG_Y_SCALE    = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ACT_STORE   = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  typedef enum logic {
    MODE_BILINEAR = 1'b0,
    MODE_NEAREST  = 1'b1
  } mode_e;

  typedef struct packed {
    logic             en;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [PIX_W-1:0] data;
  } bir_wr_t;

  typedef struct packed {
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y0;
    logic [YW-1:0] y1;
  } bir_rd_t;

  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p11;
  } bir_quad_t;

endpackage

@@ hdl/bir_if.sv @@
// ----------------------------------------------------------------------------
// bir_if: request and result channels of the bilinear image resizer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface bir_in_if;
  import bir_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, action, pos_x, pos_y, pixel_in, input ready);
  modport sink (input valid, action, pos_x, pos_y, pixel_in, output ready);
endinterface

interface bir_out_if;
  import bir_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_x;
  logic [POS_W-1:0] out_y;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, out_x, out_y, pixel_out, input ready);
  modport sink (input valid, out_x, out_y, pixel_out, output ready);
endinterface

@@ hdl/bir_store.sv @@
// ----------------------------------------------------------------------------
// bir_store: source image store, four banks by row and column parity
// One write port and one registered read per bank, so the four neighbours
// of a 2x2 window come out together from the registered read.
// ----------------------------------------------------------------------------
module bir_store (
  input  logic               clk_i,
  input  logic               en_i,
  input  bir_pkg::bir_wr_t   wr_i,
  input  bir_pkg::bir_rd_t   rd_i,
  output bir_pkg::bir_quad_t pix_o
);
  import bir_pkg::*;

  typedef struct packed {
    logic x0;
    logic x1;
    logic y0;
    logic y1;
  } par_t;

  logic [PIX_W-1:0]   bank_rd [4];
  logic [1:0]         wr_bank;
  logic [BANK_AW-1:0] wr_addr;
  par_t               par_q;

  assign wr_bank = {wr_i.y[0], wr_i.x[0]};
  assign wr_addr = {wr_i.y[YW-1:1], wr_i.x[XW-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit XB = (b % 2) == 1;
    localparam bit YB = (b / 2) == 1;

    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [PIX_W-1:0]   rdata_q;
    logic [XW-2:0]      col;
    logic [YW-2:0]      row;

    // pick whichever neighbour column / row falls in this bank
    always_comb begin
      col = (rd_i.x0[0] == XB) ? rd_i.x0[XW-1:1] : rd_i.x1[XW-1:1];
      row = (rd_i.y0[0] == YB) ? rd_i.y0[YW-1:1] : rd_i.y1[YW-1:1];
    end

    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_bank == 2'(b)) begin
        mem[wr_addr] <= wr_i.data;
      end
      if (en_i) begin
        rdata_q <= mem[{row, col}];
      end
    end

    assign bank_rd[b] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par_q <= '{x0: rd_i.x0[0], x1: rd_i.x1[0], y0: rd_i.y0[0], y1: rd_i.y1[0]};
    end
  end

  assign pix_o.p00 = bank_rd[{par_q.y0, par_q.x0}];
  assign pix_o.p10 = bank_rd[{par_q.y0, par_q.x1}];
  assign pix_o.p01 = bank_rd[{par_q.y1, par_q.x0}];
  assign pix_o.p11 = bank_rd[{par_q.y1, par_q.x1}];

endmodule

@@ hdl/bilinear_image_resize_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_resize_top: bilinear / nearest-neighbour image scaler
// Takes one item per clock while the result is not stalled and returns one
// destination pixel per compute request, through the registered pipeline.
// ----------------------------------------------------------------------------
// Store requests write one 8-bit source pixel; compute requests return one
// destination pixel, in request order. The pipeline takes a new request
// every clock while the result side keeps up: the scale multiply, the
// coordinate clamp with the store read, the horizontal blend and the
// vertical blend each take one stage, and the vertical blend lands in the
// result register, the fourth. The source store is split into four banks
// by row and column parity, so the four neighbours come from one read
// access. A stalled result freezes the whole pipeline. Configure through APB
// only while no request is in flight.
module bilinear_image_resize_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bir_in_if.sink                        req_i,
  bir_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bir_pkg::APB_AW-1:0]    paddr,
  input  logic [bir_pkg::APB_DW-1:0]    pwdata,
  output logic [bir_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import bir_pkg::*;

  // configuration
  logic               mode_q;
  logic [SIZE_W-1:0]  src_width_q;
  logic [SIZE_W-1:0]  src_height_q;
  logic [SCALE_W-1:0] x_scale_q;
  logic [SCALE_W-1:0] y_scale_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // pipeline
  logic adv;

  logic              a_valid_q;
  logic              a_act_q;
  logic [POS_W-1:0]  a_x_q;
  logic [POS_W-1:0]  a_y_q;
  logic [PIX_W-1:0]  a_pix_q;
  logic [PROD_W-1:0] a_fx_full_q;
  logic [PROD_W-1:0] a_fy_full_q;

  logic                       b_valid_q;
  logic [POS_W-1:0]           b_x_q;
  logic [POS_W-1:0]           b_y_q;
  logic [COORD_FRAC_BITS-1:0] b_fx_q;
  logic [COORD_FRAC_BITS-1:0] b_fy_q;

  logic                       c_valid_q;
  logic [POS_W-1:0]           c_x_q;
  logic [POS_W-1:0]           c_y_q;
  logic [COORD_FRAC_BITS-1:0] c_fy_q;
  logic [HSUM_W-1:0]          c_top_q;
  logic [HSUM_W-1:0]          c_bot_q;

  logic             out_valid_q;
  logic [POS_W-1:0] out_x_q;
  logic [POS_W-1:0] out_y_q;
  logic [PIX_W-1:0] out_pix_q;

  // stage a combinational
  logic [XW-1:0]              wm1;
  logic [YW-1:0]              hm1;
  logic [SX_W-1:0]            sx_bil;
  logic [SX_W-1:0]            sy_bil;
  logic [IX_W-1:0]            ix;
  logic [IX_W-1:0]            iy;
  logic [COORD_FRAC_BITS-1:0] fx;
  logic [COORD_FRAC_BITS-1:0] fy;
  logic [IX_W:0]              ix1;
  logic [IX_W:0]              iy1;
  bir_rd_t                    rd;
  bir_wr_t                    wr;
  logic                       st_in_range;

  // stage b combinational
  bir_quad_t                  quad;
  logic [WT_W-1:0]            wfx0;
  logic [WT_W-1:0]            wfx1;
  logic [HSUM_W-1:0]          top;
  logic [HSUM_W-1:0]          bot;

  // stage c combinational
  logic [WT_W-1:0]            wfy0;
  logic [WT_W-1:0]            wfy1;
  logic [VSUM_W:0]            vsum;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_BILINEAR;
      src_width_q  <= SIZE_W'(256);
      src_height_q <= SIZE_W'(256);
      x_scale_q    <= SCALE_W'(65536);
      y_scale_q    <= SCALE_W'(65536);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:       mode_q       <= pwdata[0];
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SIZE_W-1:0];
        REG_X_SCALE:    x_scale_q    <= pwdata[SCALE_W-1:0];
        REG_Y_SCALE:    y_scale_q    <= pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:       prdata = APB_DW'(mode_q);
      REG_SRC_WIDTH:  prdata = APB_DW'(src_width_q);
      REG_SRC_HEIGHT: prdata = APB_DW'(src_height_q);
      REG_X_SCALE:    prdata = APB_DW'(x_scale_q);
      REG_Y_SCALE:    prdata = APB_DW'(y_scale_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: everything moves together unless the result stalls
  // --------------------------------------------------------------------------
  assign adv         = !out_valid_q || res_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= req_i.valid;
      b_valid_q   <= a_valid_q && (a_act_q == ACT_COMPUTE);
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage a: centre times scale
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_act_q     <= req_i.action;
      a_x_q       <= req_i.pos_x;
      a_y_q       <= req_i.pos_y;
      a_pix_q     <= req_i.pixel_in;
      a_fx_full_q <= PROD_W'({req_i.pos_x, 1'b1}) * PROD_W'(x_scale_q);
      a_fy_full_q <= PROD_W'({req_i.pos_y, 1'b1}) * PROD_W'(y_scale_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage a -> b: source coordinate, edge clamp, store access
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (src_width_q == '0) begin
      wm1 = '0;
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(src_width_q - SIZE_W'(1));
    end
    priority if (src_height_q == '0) begin
      hm1 = '0;
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(src_height_q - SIZE_W'(1));
    end
  end

  // bilinear coordinate (2d+1)*scale/2 - 1/2, negative taken as zero
  always_comb begin
    logic [PROD_W-1:0] dx;
    logic [PROD_W-1:0] dy;
    dx     = a_fx_full_q - HALF_FULL;
    dy     = a_fy_full_q - HALF_FULL;
    sx_bil = (a_fx_full_q < HALF_FULL) ? '0 : dx[PROD_W-1:FULL_FRAC-COORD_FRAC_BITS];
    sy_bil = (a_fy_full_q < HALF_FULL) ? '0 : dy[PROD_W-1:FULL_FRAC-COORD_FRAC_BITS];
  end

  // nearest mode is bilinear with zero fraction at floor of the centre
  always_comb begin
    if (mode_q == MODE_NEAREST) begin
      ix = a_fx_full_q[PROD_W-1:FULL_FRAC];
      iy = a_fy_full_q[PROD_W-1:FULL_FRAC];
      fx = '0;
      fy = '0;
    end else begin
      ix = sx_bil[SX_W-1:COORD_FRAC_BITS];
      iy = sy_bil[SX_W-1:COORD_FRAC_BITS];
      fx = sx_bil[COORD_FRAC_BITS-1:0];
      fy = sy_bil[COORD_FRAC_BITS-1:0];
    end
    ix1   = {1'b0, ix} + (IX_W + 1)'(1);
    iy1   = {1'b0, iy} + (IX_W + 1)'(1);
    rd.x0 = (ix > IX_W'(wm1)) ? wm1 : ix[XW-1:0];
    rd.x1 = (ix1 > (IX_W + 1)'(wm1)) ? wm1 : ix1[XW-1:0];
    rd.y0 = (iy > IX_W'(hm1)) ? hm1 : iy[YW-1:0];
    rd.y1 = (iy1 > (IX_W + 1)'(hm1)) ? hm1 : iy1[YW-1:0];
  end

  // stores outside the array are dropped
  assign st_in_range = (32'(a_x_q) < MAX_WIDTH) && (32'(a_y_q) < MAX_HEIGHT);

  assign wr.en   = adv && a_valid_q && (a_act_q == ACT_STORE) && st_in_range;
  assign wr.x    = XW'(a_x_q);
  assign wr.y    = YW'(a_y_q);
  assign wr.data = a_pix_q;

  bir_store u_store (
    .clk_i (clk_i),
    .en_i  (adv),
    .wr_i  (wr),
    .rd_i  (rd),
    .pix_o (quad)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_x_q  <= a_x_q;
      b_y_q  <= a_y_q;
      b_fx_q <= fx;
      b_fy_q <= fy;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: horizontal blend of both rows
  // --------------------------------------------------------------------------
  assign wfx1 = WT_W'(b_fx_q);
  assign wfx0 = WT_ONE - wfx1;
  assign top  = HSUM_W'(quad.p00) * HSUM_W'(wfx0) + HSUM_W'(quad.p10) * HSUM_W'(wfx1);
  assign bot  = HSUM_W'(quad.p01) * HSUM_W'(wfx0) + HSUM_W'(quad.p11) * HSUM_W'(wfx1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_x_q   <= b_x_q;
      c_y_q   <= b_y_q;
      c_fy_q  <= b_fy_q;
      c_top_q <= top;
      c_bot_q <= bot;
    end
  end

  // --------------------------------------------------------------------------
  // stage c: vertical blend, round to nearest
  // --------------------------------------------------------------------------
  assign wfy1 = WT_W'(c_fy_q);
  assign wfy0 = WT_ONE - wfy1;
  assign vsum = (VSUM_W + 1)'(VSUM_W'(c_top_q) * VSUM_W'(wfy0))
              + (VSUM_W + 1)'(VSUM_W'(c_bot_q) * VSUM_W'(wfy1))
              + ROUND_ADD;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q   <= c_x_q;
      out_y_q   <= c_y_q;
      out_pix_q <= vsum[2*COORD_FRAC_BITS+PIX_W-1:2*COORD_FRAC_BITS];
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_x     = out_x_q;
  assign res_o.out_y     = out_y_q;
  assign res_o.pixel_out = out_pix_q;

endmodule
